// ===== rtl/core/dsprc_pkg.sv =====
// Shared types, register codes and reset constants for the switch relay controller.
package dsprc_pkg;

  // Configuration registers are all this wide.
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETTLE_TICKS      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE_TICKS     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_TIME           = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_GAP_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUARTER_GAP_TICKS = 3'd4;

  // Register values after reset.
  localparam logic [CFG_WIDTH-1:0] SETTLE_TICKS_RESET      = 16'd100;
  localparam logic [CFG_WIDTH-1:0] RELEASE_TICKS_RESET     = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] ON_TIME_RESET           = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] HALF_GAP_TICKS_RESET    = 16'd5000;
  localparam logic [CFG_WIDTH-1:0] QUARTER_GAP_TICKS_RESET = 16'd10000;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_CONSTANT = 2'd1,
    MODE_HALF     = 2'd2,
    MODE_QUARTER  = 2'd3
  } mode_t;

  // Current register settings.
  typedef struct packed {
    logic [CFG_WIDTH-1:0] settle_ticks;
    logic [CFG_WIDTH-1:0] release_ticks;
    logic [CFG_WIDTH-1:0] on_time;
    logic [CFG_WIDTH-1:0] half_gap_ticks;
    logic [CFG_WIDTH-1:0] quarter_gap_ticks;
  } cfg_t;

  // Input word.
  typedef struct packed {
    logic tick;
    logic switch_edge;
    logic switch_level;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic  drive_on;
    mode_t mode;
  } out_word_t;

  // Controller state seen by the top level.
  typedef struct packed {
    mode_t mode;
    logic  drive;
    logic  debounce_active;
    logic  cooldown_active;
    logic  pulse_active;
  } status_t;

endpackage

// ===== rtl/core/debounced_switch_pulse_relay_control_top.sv =====
// Top level of the debounced switch to pulsed relay controller.
//
// Input channel (in_valid / in_stall / in_word): one word per switch event or
// millisecond tick, carrying tick, switch_edge and switch_level. Every
// accepted word yields exactly one result word on the output channel
// (out_valid / out_stall / out_word) with the drive level and the mode
// after that word has been applied.
// Throughput is one word per cycle while in_stall is low; the state update is a single pass of
// logic over three countdown decrements and the mode step. Each result is
// registered in the output register, or in the skid entry when it stalls.
// When the receiver stalls, the output register holds its word and one more
// result goes into a skid entry; in_stall rises only once that entry is full
// and drops the cycle after the receiver takes a word.
// Synchronous reset clears the mode to idle, the drive off, all timers
// inactive, both output entries empty, and reloads the register defaults.
// Configuration (cfg_write / cfg_index / cfg_data) takes one register per
// cycle with no wait; unknown indexes are ignored. Write only while idle.
module debounced_switch_pulse_relay_control_top #(
  parameter int COUNT_WIDTH = dsprc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  dsprc_pkg::in_word_t                   in_word,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output dsprc_pkg::out_word_t                  out_word,
  input  logic                                  cfg_write,
  input  logic [dsprc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [dsprc_pkg::CFG_WIDTH-1:0]       cfg_data
);
  import dsprc_pkg::*;

  cfg_t      cfg;
  out_word_t res_word;
  status_t   status;
  logic      accept;
  logic      full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  dsprc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dsprc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_word  (in_word),
    .cfg      (cfg),
    .res_word (res_word),
    .status   (status)
  );

  dsprc_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (res_word),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Idle mode always has the drive off.
  a_idle_drive_off: assert property (@(posedge clk) disable iff (rst)
    status.mode == MODE_IDLE |-> !status.drive)
    else $error("drive on in idle mode");

  // Constant mode always has the drive on and no pulsing.
  a_constant_drive_on: assert property (@(posedge clk) disable iff (rst)
    status.mode == MODE_CONSTANT |-> status.drive && !status.pulse_active)
    else $error("constant mode without steady drive");

  // Pulsing runs only in half or quarter mode.
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    status.pulse_active |-> status.mode == MODE_HALF || status.mode == MODE_QUARTER)
    else $error("pulse timer active outside pulsing modes");

  // A word taken while the output is stalled lands in the skid entry.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    accept && out_valid && out_stall |=> full && out_valid)
    else $error("stalled result lost");

endmodule

// ===== rtl/core/dsprc_cfg_regs.sv =====
// Configuration register file for the switch relay controller.
module dsprc_cfg_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dsprc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [dsprc_pkg::CFG_WIDTH-1:0]        cfg_data,
  output dsprc_pkg::cfg_t                        cfg
);
  import dsprc_pkg::*;

  // Decode the index and store the word; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks      <= SETTLE_TICKS_RESET;
      cfg.release_ticks     <= RELEASE_TICKS_RESET;
      cfg.on_time           <= ON_TIME_RESET;
      cfg.half_gap_ticks    <= HALF_GAP_TICKS_RESET;
      cfg.quarter_gap_ticks <= QUARTER_GAP_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETTLE_TICKS:      cfg.settle_ticks      <= cfg_data;
        REG_RELEASE_TICKS:     cfg.release_ticks     <= cfg_data;
        REG_ON_TIME:           cfg.on_time           <= cfg_data;
        REG_HALF_GAP_TICKS:    cfg.half_gap_ticks    <= cfg_data;
        REG_QUARTER_GAP_TICKS: cfg.quarter_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/dsprc_core.sv =====
// Mode, drive and timer state with the per-word update logic.
module dsprc_core #(
  parameter int COUNT_WIDTH = dsprc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  dsprc_pkg::in_word_t   in_word,
  input  dsprc_pkg::cfg_t       cfg,
  output dsprc_pkg::out_word_t  res_word,
  output dsprc_pkg::status_t    status
);
  import dsprc_pkg::*;

  mode_t                  mode_reg;
  logic                   drive_reg;
  logic                   debounce_active;
  logic [COUNT_WIDTH-1:0] debounce_count;
  logic                   cooldown_active;
  logic [COUNT_WIDTH-1:0] cooldown_count;
  logic                   pulse_active;
  logic [COUNT_WIDTH-1:0] pulse_count;

  mode_t                  mode_next;
  logic                   drive_next;
  logic                   debounce_active_next;
  logic [COUNT_WIDTH-1:0] debounce_count_next;
  logic                   cooldown_active_next;
  logic [COUNT_WIDTH-1:0] cooldown_count_next;
  logic                   pulse_active_next;
  logic [COUNT_WIDTH-1:0] pulse_count_next;
  logic                   cooldown_loaded;
  logic                   pulse_loaded;

  // Apply the edge, then the tick handlers in order debounce, cooldown, pulse.
  always_comb begin
    mode_next            = mode_reg;
    drive_next           = drive_reg;
    debounce_active_next = debounce_active;
    debounce_count_next  = debounce_count;
    cooldown_active_next = cooldown_active;
    cooldown_count_next  = cooldown_count;
    pulse_active_next    = pulse_active;
    pulse_count_next     = pulse_count;
    cooldown_loaded      = 1'b0;
    pulse_loaded         = 1'b0;

    // Arm the debounce on an edge unless one is running.
    if (in_word.switch_edge && !debounce_active) begin
      debounce_count_next  = COUNT_WIDTH'(cfg.settle_ticks);
      debounce_active_next = 1'b1;
    end

    if (in_word.tick) begin
      // Debounce expiry: sample the level.
      if (debounce_active_next) begin
        debounce_count_next = debounce_count_next - 1'b1;
        if (debounce_count_next == '0) begin
          debounce_active_next = 1'b0;
          if (in_word.switch_level) begin
            cooldown_active_next = 1'b0;
            case (mode_next)
              MODE_IDLE:     mode_next = MODE_CONSTANT;
              MODE_CONSTANT: mode_next = MODE_HALF;
              default:       mode_next = MODE_QUARTER;
            endcase
            drive_next = 1'b1;
            if (mode_next == MODE_CONSTANT) begin
              pulse_active_next = 1'b0;
            end else begin
              pulse_count_next  = COUNT_WIDTH'(cfg.on_time);
              pulse_active_next = 1'b1;
              pulse_loaded      = 1'b1;
            end
          end else begin
            cooldown_count_next  = COUNT_WIDTH'(cfg.release_ticks);
            cooldown_active_next = 1'b1;
            cooldown_loaded      = 1'b1;
          end
        end
      end

      // Cooldown expiry: back to idle, output off.
      if (cooldown_active_next && !cooldown_loaded) begin
        cooldown_count_next = cooldown_count_next - 1'b1;
        if (cooldown_count_next == '0) begin
          cooldown_active_next = 1'b0;
          mode_next            = MODE_IDLE;
          pulse_active_next    = 1'b0;
          drive_next           = 1'b0;
        end
      end

      // Pulse expiry: toggle the drive in half and quarter mode.
      if (pulse_active_next && !pulse_loaded) begin
        pulse_count_next = pulse_count_next - 1'b1;
        if (pulse_count_next == '0) begin
          pulse_active_next = 1'b0;
          if (mode_next == MODE_HALF || mode_next == MODE_QUARTER) begin
            pulse_active_next = 1'b1;
            if (drive_next) begin
              drive_next       = 1'b0;
              pulse_count_next = (mode_next == MODE_HALF) ?
                                 COUNT_WIDTH'(cfg.half_gap_ticks) :
                                 COUNT_WIDTH'(cfg.quarter_gap_ticks);
            end else begin
              drive_next       = 1'b1;
              pulse_count_next = COUNT_WIDTH'(cfg.on_time);
            end
          end
        end
      end
    end
  end

  // Hold state between accepted words.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_IDLE;
      drive_reg       <= 1'b0;
      debounce_active <= 1'b0;
      debounce_count  <= '0;
      cooldown_active <= 1'b0;
      cooldown_count  <= '0;
      pulse_active    <= 1'b0;
      pulse_count     <= '0;
    end else if (accept) begin
      mode_reg        <= mode_next;
      drive_reg       <= drive_next;
      debounce_active <= debounce_active_next;
      debounce_count  <= debounce_count_next;
      cooldown_active <= cooldown_active_next;
      cooldown_count  <= cooldown_count_next;
      pulse_active    <= pulse_active_next;
      pulse_count     <= pulse_count_next;
    end
  end

  assign res_word.drive_on = drive_next;
  assign res_word.mode     = mode_next;

  assign status.mode            = mode_reg;
  assign status.drive           = drive_reg;
  assign status.debounce_active = debounce_active;
  assign status.cooldown_active = cooldown_active;
  assign status.pulse_active    = pulse_active;

endmodule

// ===== rtl/core/dsprc_out_skid.sv =====
// Output register with one skid entry so input is taken while output stalls.
module dsprc_out_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dsprc_pkg::out_word_t  push_word,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dsprc_pkg::out_word_t  out_word
);
  import dsprc_pkg::*;

  logic      skid_valid;
  out_word_t skid_word;

  // Advance the output register, park a word in the skid entry when stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_word <= push_word;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_valid <= 1'b1;
        out_word  <= push_word;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_word  <= push_word;
    end
  end

  assign full = skid_valid;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the debounced switch pulse relay controller.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsprc_pkg::*;

  localparam int CW = COUNT_WIDTH_DEFAULT;

  // Directed stimulus row: input word, whether a typed result is given, that result.
  typedef struct packed {
    in_word_t  w;
    logic      given;
    out_word_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  // Rows from this one on run with every timer register at one tick.
  localparam int LOW_CFG_ROW = 2;

  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    // reset state: nothing armed
    '{'{1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b1}, 1'b1, '{1'b0, MODE_IDLE}},
    // edge and tick in one word: arm, then expire on the same tick
    '{'{1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, MODE_CONSTANT}},
    '{'{1'b1, 1'b0, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    // release: arm, sample low, cooldown to idle
    '{'{1'b0, 1'b1, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, MODE_IDLE}},
    // step constant, half, pulse through on and off
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    // quarter, then saturate at quarter
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b0, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    // edge while debouncing is ignored; pulse and debounce on one tick
    '{'{1'b0, 1'b1, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    // cooldown expiry stops pulsing and drops to idle
    '{'{1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, MODE_IDLE}},
    // high level cancels a running cooldown
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, MODE_IDLE}},
    '{'{1'b0, 1'b0, 1'b0}, 1'b0, '{1'b0, MODE_IDLE}}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  in_word_t                   in_word = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_word_t                  out_word;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;

  int send_idle_pct = 15;
  int recv_idle_pct = 85;
  int fails = 0;

  // Expected relay words, oldest first.
  out_word_t relay_expect [$];

  // Shadow of the controller: settings, mode, drive and the three countdowns.
  cfg_t          settings = '{SETTLE_TICKS_RESET, RELEASE_TICKS_RESET, ON_TIME_RESET,
                              HALF_GAP_TICKS_RESET, QUARTER_GAP_TICKS_RESET};
  mode_t         mode_q = MODE_IDLE;
  logic          drive_q = 1'b0;
  logic          db_act = 1'b0, cd_act = 1'b0, pl_act = 1'b0;
  logic [CW-1:0] db_cnt = '0, cd_cnt = '0, pl_cnt = '0;

  // Level of the modeled switch pin for well-formed edges.
  logic sw_level = 1'b0;

  debounced_switch_pulse_relay_control_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Truncate a register value to the counter width.
  function automatic logic [CW-1:0] count_load(input logic [CFG_WIDTH-1:0] v);
    return CW'(v);
  endfunction

  // Apply one word to the shadow state and return the relay word it leaves.
  task automatic relay_advance(input in_word_t w, output out_word_t r);
    logic cd_fresh;
    logic pl_fresh;
    cd_fresh = 1'b0;
    pl_fresh = 1'b0;
    // an edge arms the debounce unless it is already running
    if (w.switch_edge && !db_act) begin
      db_cnt = count_load(settings.settle_ticks);
      db_act = 1'b1;
    end
    if (w.tick) begin
      // debounce expiry samples the level
      if (db_act) begin
        db_cnt = db_cnt - 1'b1;
        if (db_cnt == '0) begin
          db_act = 1'b0;
          if (w.switch_level) begin
            cd_act = 1'b0;
            if (mode_q != MODE_QUARTER) mode_q = mode_t'(mode_q + 2'd1);
            drive_q = 1'b1;
            if (mode_q == MODE_CONSTANT) begin
              pl_act = 1'b0;
            end else begin
              pl_cnt = count_load(settings.on_time);
              pl_act = 1'b1;
              pl_fresh = 1'b1;
            end
          end else begin
            cd_cnt = count_load(settings.release_ticks);
            cd_act = 1'b1;
            cd_fresh = 1'b1;
          end
        end
      end
      // cooldown expiry drops back to idle
      if (cd_act && !cd_fresh) begin
        cd_cnt = cd_cnt - 1'b1;
        if (cd_cnt == '0) begin
          cd_act = 1'b0;
          mode_q = MODE_IDLE;
          pl_act = 1'b0;
          drive_q = 1'b0;
        end
      end
      // pulse expiry toggles the drive in half and quarter mode
      if (pl_act && !pl_fresh) begin
        pl_cnt = pl_cnt - 1'b1;
        if (pl_cnt == '0) begin
          pl_act = 1'b0;
          if (mode_q == MODE_HALF || mode_q == MODE_QUARTER) begin
            if (drive_q) begin
              drive_q = 1'b0;
              pl_cnt = count_load(mode_q == MODE_HALF ? settings.half_gap_ticks
                                                      : settings.quarter_gap_ticks);
            end else begin
              drive_q = 1'b1;
              pl_cnt = count_load(settings.on_time);
            end
            pl_act = 1'b1;
          end
        end
      end
    end
    r.drive_on = drive_q;
    r.mode = mode_q;
  endtask

  // Present one word, hold it until accepted, then queue its expected result.
  task automatic send_word(input in_word_t w, input logic given, input out_word_t want);
    out_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    relay_advance(w, r);
    relay_expect.push_back(given ? want : r);
  endtask

  // Wait until every expected word has come back and the block is quiet.
  task automatic drain;
    in_valid <= 1'b0;
    while (relay_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow settings.
  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_WIDTH-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_SETTLE_TICKS:      settings.settle_ticks = data;
      REG_RELEASE_TICKS:     settings.release_ticks = data;
      REG_ON_TIME:           settings.on_time = data;
      REG_HALF_GAP_TICKS:    settings.half_gap_ticks = data;
      REG_QUARTER_GAP_TICKS: settings.quarter_gap_ticks = data;
      default: ;
    endcase
  endtask

  // Drain, then load a full set of timer registers plus one unknown index.
  task automatic apply_settings(input cfg_t c);
    drain();
    put_reg(REG_SETTLE_TICKS, c.settle_ticks);
    put_reg(REG_RELEASE_TICKS, c.release_ticks);
    put_reg(REG_ON_TIME, c.on_time);
    put_reg(REG_HALF_GAP_TICKS, c.half_gap_ticks);
    put_reg(REG_QUARTER_GAP_TICKS, c.quarter_gap_ticks);
    put_reg(CFG_INDEX_WIDTH'($urandom_range(5, 7)), CFG_WIDTH'($urandom));
    cfg_write <= 1'b0;
  endtask

  // Mostly clean switch changes, some bounce noise, ticks most of the time.
  function automatic in_word_t switch_word();
    in_word_t w;
    int r;
    r = $urandom_range(99);
    w.tick = ($urandom_range(99) < 75);
    if (r < 12) begin
      sw_level = ~sw_level;
      w.switch_edge = 1'b1;
      w.switch_level = sw_level;
    end else if (r < 20) begin
      w.switch_edge = 1'($urandom);
      w.switch_level = 1'($urandom);
    end else begin
      w.switch_edge = 1'b0;
      w.switch_level = sw_level;
    end
    return w;
  endfunction

  task automatic random_items(input int n);
    repeat (n) send_word(switch_word(), 1'b0, '0);
  endtask

  // Receiver: random stall, compare each accepted word with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_word_t want;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (relay_expect.size() == 0) begin
        $display("%0t: unexpected word drive_on=%b mode=%0d", $time,
                 out_word.drive_on, out_word.mode);
        fails++;
      end else begin
        want = relay_expect.pop_front();
        if (out_word.drive_on !== want.drive_on) begin
          $display("%0t: drive_on expected %b actual %b", $time,
                   want.drive_on, out_word.drive_on);
          fails++;
        end
        if (out_word.mode !== want.mode) begin
          $display("%0t: mode expected %0d actual %0d", $time, want.mode, out_word.mode);
          fails++;
        end
      end
    end
  end

  initial begin
    cfg_t rnd;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; all timers drop to one tick partway in.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == LOW_CFG_ROW) apply_settings('{16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
      send_word(DIR_TABLE[i].w, DIR_TABLE[i].given, DIR_TABLE[i].want);
    end

    // Sender mostly busy, receiver mostly stalled.
    apply_settings('{16'd3, 16'd5, 16'd2, 16'd4, 16'd6});
    random_items(450);

    // Swap the idling sides.
    drain();
    send_idle_pct = 85;
    recv_idle_pct <= 15;
    apply_settings('{16'd2, 16'd7, 16'd3, 16'd1, 16'd5});
    random_items(450);

    // No idling from here on.
    drain();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    apply_settings('{16'd1, 16'hFFFF, 16'd1, 16'd2, 16'hFFFF});
    random_items(200);

    rnd.settle_ticks = CFG_WIDTH'($urandom_range(1, 9));
    rnd.release_ticks = CFG_WIDTH'($urandom_range(1, 9));
    rnd.on_time = CFG_WIDTH'($urandom_range(1, 9));
    rnd.half_gap_ticks = CFG_WIDTH'($urandom_range(1, 9));
    rnd.quarter_gap_ticks = CFG_WIDTH'($urandom_range(1, 9));
    apply_settings(rnd);
    random_items(200);

    // Zero debounce register: the countdown wraps, so it stays armed over these ticks.
    apply_settings('{16'd0, 16'd1, 16'd1, 16'd1, 16'd1});
    send_word('{1'b1, 1'b1, 1'b1}, 1'b0, '0);
    repeat (179) send_word('{1'b1, 1'($urandom), 1'($urandom)}, 1'b0, '0);

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
